>>> src/vrap_pkg.sv
// ----------------------------------------------------------------------------
// vrap_pkg: shared definitions for the video memory access port
// Register offsets, control field codes and the address remap function.
// ----------------------------------------------------------------------------
package vrap_pkg;

   // Default word address width (64 KiB of 16-bit words)
   localparam int ADDR_BITS_DEFAULT = 15;

   // Access kind carried on tuser
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Write offsets
   localparam logic [7:0] OFF_CONTROL = 8'h15;
   localparam logic [7:0] OFF_ADDR_LO = 8'h16;
   localparam logic [7:0] OFF_ADDR_HI = 8'h17;
   localparam logic [7:0] OFF_DATA_LO = 8'h18;
   localparam logic [7:0] OFF_DATA_HI = 8'h19;

   // Read offsets
   localparam logic [7:0] OFF_PREFETCH_LO = 8'h39;
   localparam logic [7:0] OFF_PREFETCH_HI = 8'h3A;

   // Step codes (control bits 1:0); any other code steps by 128
   localparam logic [1:0] STEP_1  = 2'd0;
   localparam logic [1:0] STEP_32 = 2'd1;

   // Remap codes (control bits 3:2)
   localparam logic [1:0] REMAP_NONE = 2'd0;
   localparam logic [1:0] REMAP_8    = 2'd1;
   localparam logic [1:0] REMAP_9    = 2'd2;
   localparam logic [1:0] REMAP_10   = 2'd3;

   // Stored part of the control register
   typedef struct packed {
      logic       high_advance;   // advance after the high-byte access
      logic [1:0] remap;
      logic [1:0] step;
   } ctrl_type;

   // Rotate the low 8, 9 or 10 address bits left by 3
   function automatic logic [15:0] remap_addr(input logic [1:0] mode, input logic [15:0] a);
      logic [15:0] r;
      r = a;
      unique case (mode)
         REMAP_8:  r = {a[15:8],  a[4:0], a[7:5]};
         REMAP_9:  r = {a[15:9],  a[5:0], a[8:6]};
         REMAP_10: r = {a[15:10], a[6:0], a[9:7]};
         default:  r = a;
      endcase
      return r;
   endfunction

endpackage

>>> src/vram_access_port_remap.sv
// ----------------------------------------------------------------------------
// vram_access_port_remap: byte-wide register port to a 16-bit video memory
// Control, address and data registers with auto-increment, address remap
// and a prefetch latch for reads.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+----------------
//   req     | in  | tuser: op; tdata: reg_offset, wdata  | tvalid/tready
//   rsp     | out | tdata: rdata                         | tvalid/tready
//
// One beat per cycle in, one beat per cycle out while rsp_tready holds high;
// a request beat is held in the input register, and its result then in the
// result register, from which its beat leaves.
// Each beat makes at most one access to the single-port word memory.
// After reset the memory is swept to zero, one word per cycle, over all
// 2^ADDR_BITS words; req_tready stays low for that time.
// A stalled result holds the request stage, which then drops req_tready.
//
module vram_access_port_remap
   import vrap_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] reg_offset, [15:8] wdata
   input  logic        req_tuser,   // [0] op
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [7:0] rdata
);

   localparam int WORDS = 1 << ADDR_BITS;

   // memory as two byte lanes
   logic [7:0] mem_lo_ff [WORDS];
   logic [7:0] mem_hi_ff [WORDS];

   // clearing sweep
   logic                 clearing_ff, clearing_in;
   logic [ADDR_BITS-1:0] clear_addr_ff, clear_addr_in;

   // request stage
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   logic [7:0] s1_off_ff;
   logic [7:0] s1_wdata_ff;
   logic       s1_adv;

   // port state
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   ctrl_type             ctrl_ff, ctrl_in;
   logic [15:0]          prefetch_ff;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   // decode and memory controls
   logic                 wr_ctrl, wr_addr_lo, wr_addr_hi, wr_data_lo, wr_data_hi;
   logic                 rd_pf_lo, rd_pf_hi;
   logic                 reload, advance;
   logic [ADDR_BITS-1:0] step, new_addr, cur_map, new_map;
   logic                 lo_we, hi_we;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [7:0]           wr_byte;

   // handshakes
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // decode the held beat
   always_comb begin
      wr_ctrl    = s1_adv && (s1_op_ff == OP_WRITE) && (s1_off_ff == OFF_CONTROL);
      wr_addr_lo = s1_adv && (s1_op_ff == OP_WRITE) && (s1_off_ff == OFF_ADDR_LO);
      wr_addr_hi = s1_adv && (s1_op_ff == OP_WRITE) && (s1_off_ff == OFF_ADDR_HI);
      wr_data_lo = s1_adv && (s1_op_ff == OP_WRITE) && (s1_off_ff == OFF_DATA_LO);
      wr_data_hi = s1_adv && (s1_op_ff == OP_WRITE) && (s1_off_ff == OFF_DATA_HI);
      rd_pf_lo   = s1_adv && (s1_op_ff == OP_READ) && (s1_off_ff == OFF_PREFETCH_LO);
      rd_pf_hi   = s1_adv && (s1_op_ff == OP_READ) && (s1_off_ff == OFF_PREFETCH_HI);
      reload     = wr_addr_lo || wr_addr_hi
                   || (rd_pf_lo && !ctrl_ff.high_advance)
                   || (rd_pf_hi && ctrl_ff.high_advance);
      advance    = (wr_data_lo && !ctrl_ff.high_advance)
                   || (wr_data_hi && ctrl_ff.high_advance)
                   || (rd_pf_lo && !ctrl_ff.high_advance)
                   || (rd_pf_hi && ctrl_ff.high_advance);
   end

   // step size
   always_comb begin
      unique case (ctrl_ff.step)
         STEP_1:  step = ADDR_BITS'(1);
         STEP_32: step = ADDR_BITS'(32);
         default: step = ADDR_BITS'(128);
      endcase
   end

   // address after an address-byte write
   always_comb begin
      new_addr = addr_ff;
      if (wr_addr_lo) begin
         new_addr[7:0] = s1_wdata_ff;
      end else if (wr_addr_hi) begin
         new_addr[ADDR_BITS-1:8] = s1_wdata_ff[ADDR_BITS-9:0];
      end
   end

   // remapped access addresses
   assign cur_map = ADDR_BITS'(remap_addr(ctrl_ff.remap, 16'(addr_ff)));
   assign new_map = ADDR_BITS'(remap_addr(ctrl_ff.remap, 16'(new_addr)));

   // next port state
   always_comb begin
      ctrl_in = ctrl_ff;
      addr_in = addr_ff;
      if (wr_ctrl) begin
         ctrl_in.high_advance = s1_wdata_ff[7];
         ctrl_in.remap        = s1_wdata_ff[3:2];
         ctrl_in.step         = s1_wdata_ff[1:0];
      end
      if (wr_addr_lo || wr_addr_hi) begin
         addr_in = new_addr;
      end else if (advance) begin
         addr_in = addr_ff + step;
      end
   end

   // memory write port: sweep first, then byte writes
   always_comb begin
      lo_we   = clearing_ff || wr_data_lo;
      hi_we   = clearing_ff || wr_data_hi;
      wr_addr = clearing_ff ? clear_addr_ff : cur_map;
      wr_byte = clearing_ff ? 8'h00 : s1_wdata_ff;
   end

   // clearing sweep control
   always_comb begin
      clear_addr_in = clear_addr_ff + ADDR_BITS'(1);
      clearing_in   = clearing_ff && (clear_addr_ff != {ADDR_BITS{1'b1}});
   end

   // request and result stage next values
   always_comb begin
      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (s1_adv) begin
         priority if (rd_pf_lo) begin
            rsp_data_in = prefetch_ff[7:0];
         end else if (rd_pf_hi) begin
            rsp_data_in = prefetch_ff[15:8];
         end else begin
            rsp_data_in = 8'h00;
         end
      end
   end

   // memory byte lanes
   always_ff @(posedge clock) begin
      if (lo_we) begin
         mem_lo_ff[wr_addr] <= wr_byte;
      end
      if (hi_we) begin
         mem_hi_ff[wr_addr] <= wr_byte;
      end
   end

   // prefetch latch doubles as the registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         prefetch_ff <= 16'h0000;
      end else if (reload) begin
         prefetch_ff <= {mem_hi_ff[new_map], mem_lo_ff[new_map]};
      end
   end

   // request stage payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff    <= req_tuser;
         s1_off_ff   <= req_tdata[7:0];
         s1_wdata_ff <= req_tdata[15:8];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= 8'h00;
         addr_ff       <= '0;
         ctrl_ff       <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         addr_ff       <= addr_in;
         ctrl_ff       <= ctrl_in;
      end
   end

   // no beat is taken during the clearing sweep
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready)
      else $error("request taken during memory clear");

   // the address holds during the sweep
   a_addr_hold_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |=> $stable(addr_ff))
      else $error("address moved during memory clear");

   // a processed beat always lands in the result register
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("processed beat produced no result");

   // writes answer zero
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_op_ff == OP_WRITE)) |=> (rsp_data_ff == 8'h00))
      else $error("write access returned nonzero data");

   // reads at other offsets answer zero
   a_read_other_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_op_ff == OP_READ) && (s1_off_ff != OFF_PREFETCH_LO)
       && (s1_off_ff != OFF_PREFETCH_HI)) |=> (rsp_data_ff == 8'h00))
      else $error("unmapped read returned nonzero data");

endmodule
